[rtl/core/scpr_pkg.sv]
// ----------------------------------------------------------------------------
// Second-chance page replacement: shared definitions
// Sizes, the stored entry layout and the result layout used by the engine and the top module.
// ----------------------------------------------------------------------------
package scpr_pkg;

  // Store geometry.
  localparam int MAX_FRAMES = 64;
  localparam int SLOT_W     = $clog2(MAX_FRAMES);
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);

  // Payload widths.
  localparam int PAGE_BITS = 20;
  localparam int PROC_BITS = 8;

  // Configuration port.
  localparam int CFG_W      = 7;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Register indexes.
  localparam logic REG_FRAMES_IN_USE = 1'b0;

  // Request kinds carried on the mode field.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_MARK   = 1'b1;

  // One resident page as kept in the store.
  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic [PROC_BITS-1:0] proc;
    logic                 ref_bit;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // One result beat.
  typedef struct packed {
    logic                 valid;
    logic                 victim_valid;
    logic [PAGE_BITS-1:0] victim_page;
    logic [PROC_BITS-1:0] victim_process;
    logic                 hit;
  } result_t;

endpackage

[rtl/core/scpr_ram.sv]
// ----------------------------------------------------------------------------
// Second-chance page replacement: entry memory
// Simple dual-port synchronous RAM, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module scpr_ram #(
  parameter int DATA_W = 29,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/scpr_engine.sv]
// ----------------------------------------------------------------------------
// Second-chance page replacement: sequencer
// Writes inserts into the circular entry store and walks it for mark-used searches and the clock scan.
// ----------------------------------------------------------------------------
module scpr_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [scpr_pkg::CFG_W-1:0]     frames_in_use,
  input  logic                           start,
  input  logic                           mode,
  input  logic [scpr_pkg::PAGE_BITS-1:0] page_number,
  input  logic [scpr_pkg::PROC_BITS-1:0] process_id,
  output logic                           busy,
  output scpr_pkg::result_t              result
);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_SRCH    = 2'd1;
  localparam logic [1:0] ST_SCAN_RD = 2'd2;
  localparam logic [1:0] ST_SCAN_EV = 2'd3;

  localparam logic [scpr_pkg::CNT_W-1:0] LIMIT_MAX = scpr_pkg::CNT_W'(scpr_pkg::MAX_FRAMES);
  localparam logic [scpr_pkg::CNT_W-1:0] LIMIT_MIN = scpr_pkg::CNT_W'(1);

  logic [1:0]                       state_r, state_nxt;
  logic [scpr_pkg::SLOT_W-1:0]      hand_r, hand_nxt;
  logic [scpr_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [scpr_pkg::PAGE_BITS-1:0]   pg_r, pg_nxt;
  logic [scpr_pkg::PROC_BITS-1:0]   pid_r, pid_nxt;
  logic [scpr_pkg::SLOT_W-1:0]      iss_off_r, iss_off_nxt;
  logic [scpr_pkg::CNT_W-1:0]       iss_left_r, iss_left_nxt;
  logic                             pv_r, pv_nxt;
  logic [scpr_pkg::SLOT_W-1:0]      p_slot_r, p_slot_nxt;
  scpr_pkg::result_t                res_r, res_nxt;

  logic                             we;
  logic [scpr_pkg::SLOT_W-1:0]      waddr;
  scpr_pkg::entry_t                 wentry;
  logic [scpr_pkg::SLOT_W-1:0]      raddr;
  logic [scpr_pkg::ENTRY_W-1:0]     rdata;
  scpr_pkg::entry_t                 rentry;

  logic [scpr_pkg::CNT_W-1:0]       limit;
  logic                             full;
  logic [scpr_pkg::SLOT_W-1:0]      tail_slot;
  logic                             match;

  // Entry store.
  scpr_ram #(
    .DATA_W (scpr_pkg::ENTRY_W),
    .DEPTH  (scpr_pkg::MAX_FRAMES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rentry = scpr_pkg::entry_t'(rdata);

  // Effective frame limit, clamped to one and to the store depth.
  always_comb begin
    if (frames_in_use == '0) begin
      limit = LIMIT_MIN;
    end else if (frames_in_use > LIMIT_MAX) begin
      limit = LIMIT_MAX;
    end else begin
      limit = frames_in_use;
    end
  end

  assign full      = (cnt_r != '0) && (cnt_r >= limit);
  assign tail_slot = hand_r + cnt_r[scpr_pkg::SLOT_W-1:0];
  assign match     = (rentry.page == pg_r) && (rentry.proc == pid_r);

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    hand_nxt     = hand_r;
    cnt_nxt      = cnt_r;
    pg_nxt       = pg_r;
    pid_nxt      = pid_r;
    iss_off_nxt  = iss_off_r;
    iss_left_nxt = iss_left_r;
    pv_nxt       = 1'b0;
    p_slot_nxt   = p_slot_r;
    res_nxt      = '0;
    we           = 1'b0;
    waddr        = tail_slot;
    wentry       = '0;
    raddr        = hand_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          pg_nxt  = page_number;
          pid_nxt = process_id;
          if (mode == scpr_pkg::MODE_INSERT) begin
            if (full) begin
              state_nxt = ST_SCAN_RD;
            end else begin
              // Room left: append the page at the tail right away.
              we             = 1'b1;
              wentry.page    = page_number;
              wentry.proc    = process_id;
              wentry.ref_bit = 1'b0;
              cnt_nxt        = cnt_r + 1'b1;
              res_nxt.valid  = 1'b1;
            end
          end else if (cnt_r == '0) begin
            res_nxt.valid = 1'b1;
          end else begin
            // Search from the newest entry toward the oldest.
            iss_off_nxt  = cnt_r[scpr_pkg::SLOT_W-1:0] - 1'b1;
            iss_left_nxt = cnt_r;
            state_nxt    = ST_SRCH;
          end
        end
      end

      ST_SRCH: begin
        // One read is issued a cycle while the previous one is compared.
        raddr = hand_r + iss_off_r;
        if (iss_left_r != '0) begin
          iss_off_nxt  = iss_off_r - 1'b1;
          iss_left_nxt = iss_left_r - 1'b1;
          pv_nxt       = 1'b1;
          p_slot_nxt   = raddr;
        end
        if (pv_r) begin
          if (match) begin
            we             = 1'b1;
            waddr          = p_slot_r;
            wentry         = rentry;
            wentry.ref_bit = 1'b1;
            res_nxt.valid  = 1'b1;
            res_nxt.hit    = 1'b1;
            pv_nxt         = 1'b0;
            state_nxt      = ST_IDLE;
          end else if (iss_left_r == '0) begin
            res_nxt.valid = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end

      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_EV;
      end

      ST_SCAN_EV: begin
        we = 1'b1;
        if (rentry.ref_bit) begin
          // Second chance: recycle the oldest entry to the newest place.
          wentry         = rentry;
          wentry.ref_bit = 1'b0;
          hand_nxt       = hand_r + 1'b1;
          state_nxt      = ST_SCAN_RD;
        end else begin
          // Evict the oldest entry; the new page takes the tail slot.
          wentry.page            = pg_r;
          wentry.proc            = pid_r;
          wentry.ref_bit         = 1'b0;
          hand_nxt               = hand_r + 1'b1;
          res_nxt.valid          = 1'b1;
          res_nxt.victim_valid   = 1'b1;
          res_nxt.victim_page    = rentry.page;
          res_nxt.victim_process = rentry.proc;
          state_nxt              = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      hand_r   <= '0;
      cnt_r    <= '0;
      pv_r     <= 1'b0;
      res_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      hand_r   <= hand_nxt;
      cnt_r    <= cnt_nxt;
      pv_r     <= pv_nxt;
      res_r    <= res_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pg_r       <= pg_nxt;
    pid_r      <= pid_nxt;
    iss_off_r  <= iss_off_nxt;
    iss_left_r <= iss_left_nxt;
    p_slot_r   <= p_slot_nxt;
  end

  assign busy   = (state_r != ST_IDLE);
  assign result = res_r;

  // The resident count never exceeds the store depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LIMIT_MAX)
    else $error("resident count above store depth");

  // Every result is issued on the way back to idle.
  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_r.valid |-> state_r == ST_IDLE)
    else $error("result issued while sequencer still busy");

  // An eviction replaces one page with another, so the count holds.
  a_evict_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    res_r.victim_valid |-> $stable(cnt_r))
    else $error("resident count changed on eviction");

  // Hit and eviction never appear in the same beat.
  a_hit_evict: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_r.hit && res_r.victim_valid))
    else $error("hit and eviction in one beat");

  // The evaluate step always follows a store read.
  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN_EV |-> $past(state_r) == ST_SCAN_RD)
    else $error("scan evaluate without a preceding read");

endmodule

[rtl/core/second_chance_page_replacement_unit.sv]
// ----------------------------------------------------------------------------
// Second-chance page replacement unit
// Clock replacement over a circular store of resident pages, with an APB
// register for the frame limit.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; each request yields
// exactly one result beat, marked by out_valid for one cycle, which the
// receiver must take as it comes. An insert with free room writes the page
// and gives its result in the cycle after it is taken. A mark-used search
// reads one entry of the store per cycle from the newest entry down, and
// stops early when the match is found. An insert into a full store runs the
// clock scan, which visits each entry with a read state and then an evaluate
// and write-back state, until it finds an entry whose reference bit is clear.
// The entry memory has a single read and a single write port. No clearing
// pass follows reset; the unit is ready at once.
// ----------------------------------------------------------------------------
module second_chance_page_replacement_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [scpr_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [scpr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [scpr_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  // Request channel.
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_mode,
  input  logic [scpr_pkg::PAGE_BITS-1:0]      in_page_number,
  input  logic [scpr_pkg::PROC_BITS-1:0]      in_process_id,
  // Result channel.
  output logic                                out_valid,
  output logic                                out_victim_valid,
  output logic [scpr_pkg::PAGE_BITS-1:0]      out_victim_page,
  output logic [scpr_pkg::PROC_BITS-1:0]      out_victim_process,
  output logic                                out_hit
);

  localparam logic [scpr_pkg::CFG_W-1:0] FRAMES_RESET = scpr_pkg::CFG_W'(scpr_pkg::MAX_FRAMES);

  logic [scpr_pkg::CFG_W-1:0] frames_r, frames_nxt;
  logic                       reg_sel;
  logic                       wr_beat;
  scpr_pkg::result_t          result;

  // Register decode; the word index sits above the byte offset.
  assign reg_sel = (paddr[scpr_pkg::APB_ADDR_W-1] == scpr_pkg::REG_FRAMES_IN_USE);
  assign wr_beat = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_comb begin
    frames_nxt = frames_r;
    if (wr_beat && reg_sel) begin
      frames_nxt = pwdata[scpr_pkg::CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= FRAMES_RESET;
    end else begin
      frames_r <= frames_nxt;
    end
  end

  // Read data.
  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = {{(scpr_pkg::APB_DATA_W - scpr_pkg::CFG_W){1'b0}}, frames_r};
    end
  end

  // Replacement sequencer and entry store.
  scpr_engine u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .frames_in_use (frames_r),
    .start         (start),
    .mode          (in_mode),
    .page_number   (in_page_number),
    .process_id    (in_process_id),
    .busy          (busy),
    .result        (result)
  );

  assign out_valid          = result.valid;
  assign out_victim_valid   = result.victim_valid;
  assign out_victim_page    = result.victim_page;
  assign out_victim_process = result.victim_process;
  assign out_hit            = result.hit;

endmodule
